[hdl/ldh_pkg.sv]
// Layer density histogram: shared package.
// Field widths, register and opcode codes, pipeline control struct and
// the saturating increment. No dependencies.
package ldh_pkg;

   // Field widths
   localparam int COORD_W   = 20;
   localparam int SCALE_W   = 24;
   localparam int COUNT_W   = 32;
   localparam int SPEC_W    = 2;
   localparam int HSEL_W    = 3;
   localparam int RBIN_W    = 12;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 24;

   // Bin arithmetic: Q10.10 times Q8.16 gives Q18.26
   localparam int PROD_W    = COORD_W + SCALE_W;
   localparam int BIN_SHIFT = 26;
   localparam int RAW_BIN_W = PROD_W - BIN_SHIFT;

   // Defaults
   localparam int NUM_BINS_DEF = 4096;
   localparam int RSP_DEPTH    = 4;

   localparam logic [SCALE_W-1:0] BIN_SCALE_RST = 24'd3276800;
   localparam logic [COORD_W-1:0] THICKNESS_RST = 20'd1485;
   localparam logic [COORD_W-1:0] BOTTOM_RST    = 20'd0;
   localparam logic [COORD_W-1:0] TOP_RST       = 20'd1048575;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIN_SCALE       = 2'd0,
      CSR_LAYER_THICKNESS = 2'd1,
      CSR_BOTTOM_SURFACE  = 2'd2,
      CSR_TOP_SURFACE     = 2'd3
   } csr_index_type;

   // Opcodes and species codes
   localparam logic OPC_ACCUM = 1'b0;
   localparam logic OPC_READ  = 1'b1;

   localparam logic [SPEC_W-1:0] SPECIES_FIRST  = 2'd0;
   localparam logic [SPEC_W-1:0] SPECIES_SECOND = 2'd1;

   // Histogram select on a read
   typedef enum logic [HSEL_W-1:0] {
      HIST_BOT_TOTAL  = 3'd0,
      HIST_BOT_SECOND = 3'd1,
      HIST_BOT_FIRST  = 3'd2,
      HIST_TOP_TOTAL  = 3'd3,
      HIST_TOP_SECOND = 3'd4,
      HIST_TOP_FIRST  = 3'd5
   } hist_sel_type;

   typedef enum logic {
      KIND_ACC  = 1'b0,
      KIND_READ = 1'b1
   } kind_type;

   // Which counter a read returns
   typedef enum logic [1:0] {
      SRC_TOTAL   = 2'd0,
      SRC_SPECIES = 2'd1,
      SRC_ZERO    = 2'd2
   } src_type;

   // One memory operation handed from the front end to the store
   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic     layer;   // 0 bottom, 1 top
      logic     spbit;   // 0 first species, 1 second species
      src_type  src;
   } mem_op_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

[hdl/ldh_front.sv]
// Layer density histogram: front end (input register, bin multiply,
// layer classification, read decode). Produces at most one memory op per beat.
// Depends on ldh_pkg.
module ldh_front
   import ldh_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEF,
   localparam int BIN_W   = $clog2(NUM_BINS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_accept,
   input  logic               in_opcode,
   input  logic [COORD_W-1:0] in_x,
   input  logic [COORD_W-1:0] in_z,
   input  logic [SPEC_W-1:0]  in_species,
   input  logic [HSEL_W-1:0]  in_rhist,
   input  logic [RBIN_W-1:0]  in_rbin,
   input  logic [SCALE_W-1:0] bin_scale,
   input  logic [COORD_W-1:0] layer_thickness,
   input  logic [COORD_W-1:0] bottom_surface,
   input  logic [COORD_W-1:0] top_surface,
   output mem_op_type         op,
   output logic [BIN_W-1:0]   op_bin
);

   localparam logic [RAW_BIN_W-1:0] BIN_LIMIT = RAW_BIN_W'(NUM_BINS);

   // Stage A: captured beat
   logic               a_valid_ff, a_valid_in;
   logic               a_op_ff;
   logic [COORD_W-1:0] a_x_ff, a_z_ff;
   logic [SPEC_W-1:0]  a_sp_ff;
   logic [HSEL_W-1:0]  a_rhist_ff;
   logic [RBIN_W-1:0]  a_rbin_ff;

   // Stage P: bin and classification
   logic                 p_valid_ff, p_valid_in;
   kind_type             p_kind_ff, p_kind_in;
   logic                 p_layer_ff, p_layer_in;
   logic                 p_spbit_ff, p_spbit_in;
   src_type              p_src_ff, p_src_in;
   logic                 p_hit_ff, p_hit_in;
   logic [RAW_BIN_W-1:0] p_bin_ff, p_bin_in;

   logic [PROD_W-1:0]  prod;
   logic [COORD_W:0]   bot_end, z_end;
   logic               bot_hit, top_hit, species_ok, in_range;

   assign a_valid_in = in_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         a_op_ff    <= in_opcode;
         a_x_ff     <= in_x;
         a_z_ff     <= in_z;
         a_sp_ff    <= in_species;
         a_rhist_ff <= in_rhist;
         a_rbin_ff  <= in_rbin;
      end
   end

   // Bin product and layer windows, compared without wraparound
   always_comb begin
      prod       = PROD_W'(a_x_ff) * PROD_W'(bin_scale);
      bot_end    = {1'b0, bottom_surface} + {1'b0, layer_thickness};
      z_end      = {1'b0, a_z_ff} + {1'b0, layer_thickness};
      bot_hit    = (a_z_ff >= bottom_surface) && ({1'b0, a_z_ff} < bot_end);
      top_hit    = (a_z_ff < top_surface) && (z_end >= {1'b0, top_surface});
      species_ok = (a_sp_ff == SPECIES_FIRST) || (a_sp_ff == SPECIES_SECOND);
   end

   // Next P stage: accumulate takes the product, read decodes the select
   always_comb begin
      p_valid_in = a_valid_ff;
      p_kind_in  = KIND_ACC;
      p_layer_in = ~bot_hit;
      p_spbit_in = a_sp_ff[0];
      p_src_in   = SRC_TOTAL;
      p_hit_in   = (bot_hit || top_hit) && species_ok;
      p_bin_in   = prod[PROD_W-1:BIN_SHIFT];
      if (a_op_ff == OPC_READ) begin
         p_kind_in = KIND_READ;
         p_hit_in  = 1'b1;
         p_bin_in  = RAW_BIN_W'(a_rbin_ff);
         unique case (a_rhist_ff)
            HIST_BOT_TOTAL: begin
               p_layer_in = 1'b0; p_src_in = SRC_TOTAL;   p_spbit_in = 1'b0;
            end
            HIST_BOT_SECOND: begin
               p_layer_in = 1'b0; p_src_in = SRC_SPECIES; p_spbit_in = 1'b1;
            end
            HIST_BOT_FIRST: begin
               p_layer_in = 1'b0; p_src_in = SRC_SPECIES; p_spbit_in = 1'b0;
            end
            HIST_TOP_TOTAL: begin
               p_layer_in = 1'b1; p_src_in = SRC_TOTAL;   p_spbit_in = 1'b0;
            end
            HIST_TOP_SECOND: begin
               p_layer_in = 1'b1; p_src_in = SRC_SPECIES; p_spbit_in = 1'b1;
            end
            HIST_TOP_FIRST: begin
               p_layer_in = 1'b1; p_src_in = SRC_SPECIES; p_spbit_in = 1'b0;
            end
            default: begin
               p_layer_in = 1'b0; p_src_in = SRC_ZERO;    p_spbit_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_kind_ff  <= p_kind_in;
      p_layer_ff <= p_layer_in;
      p_spbit_ff <= p_spbit_in;
      p_src_ff   <= p_src_in;
      p_hit_ff   <= p_hit_in;
      p_bin_ff   <= p_bin_in;
   end

   // Range check: accumulate past the last bin is dropped, read returns zero
   always_comb begin
      in_range  = p_bin_ff < BIN_LIMIT;
      op.valid  = p_valid_ff && ((p_kind_ff == KIND_READ) || (p_hit_ff && in_range));
      op.kind   = p_kind_ff;
      op.layer  = p_layer_ff;
      op.spbit  = p_spbit_ff;
      op.src    = in_range ? p_src_ff : SRC_ZERO;
      op_bin    = p_bin_ff[BIN_W-1:0];
   end

endmodule

[hdl/ldh_store.sv]
// Layer density histogram: counter store. Two synchronous RAMs (layer
// totals, per-species counts), read-modify-write with one-entry forwarding,
// and the clearing sweep after reset. Depends on ldh_pkg.
module ldh_store
   import ldh_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEF,
   localparam int BIN_W   = $clog2(NUM_BINS)
) (
   input  logic               clock,
   input  logic               reset,
   input  mem_op_type         op,
   input  logic [BIN_W-1:0]   op_bin,
   output logic               clear_busy,
   output logic               push,
   output logic [COUNT_W-1:0] push_data
);

   localparam int TOT_AW = BIN_W + 1;
   localparam int SP_AW  = BIN_W + 2;

   // Total RAM: {layer, bin}; species RAM: {layer, species, bin}
   logic [COUNT_W-1:0] total_ram_ff [2**TOT_AW];
   logic [COUNT_W-1:0] species_ram_ff [2**SP_AW];
   logic [COUNT_W-1:0] tot_rd_ff, sp_rd_ff;

   logic [TOT_AW-1:0]  tot_raddr, tot_waddr, c_tot_addr;
   logic [SP_AW-1:0]   sp_raddr, sp_waddr, c_sp_addr;
   logic [COUNT_W-1:0] tot_wdata, sp_wdata, tot_cur, sp_cur;
   logic               tot_we, sp_we, acc;

   // Stage C: op whose read data is now out of the RAMs
   mem_op_type         c_op_ff;
   logic [BIN_W-1:0]   c_bin_ff;

   // Last write of each RAM, for back-to-back hits on one entry
   logic               fw_tot_valid_ff, fw_sp_valid_ff;
   logic [TOT_AW-1:0]  fw_tot_addr_ff;
   logic [SP_AW-1:0]   fw_sp_addr_ff;
   logic [COUNT_W-1:0] fw_tot_data_ff, fw_sp_data_ff;

   // Clearing sweep
   logic               clr_busy_ff, clr_busy_in;
   logic [SP_AW-1:0]   clr_idx_ff, clr_idx_in;

   assign tot_raddr  = {op.layer, op_bin};
   assign sp_raddr   = {op.layer, op.spbit, op_bin};
   assign c_tot_addr = {c_op_ff.layer, c_bin_ff};
   assign c_sp_addr  = {c_op_ff.layer, c_op_ff.spbit, c_bin_ff};
   assign clear_busy = clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_op_ff <= '0;
      end else begin
         c_op_ff <= op;
      end
   end

   always_ff @(posedge clock) begin
      c_bin_ff <= op_bin;
   end

   // Forward the previous write over the stale RAM data
   always_comb begin
      tot_cur = (fw_tot_valid_ff && (fw_tot_addr_ff == c_tot_addr)) ?
                fw_tot_data_ff : tot_rd_ff;
      sp_cur  = (fw_sp_valid_ff && (fw_sp_addr_ff == c_sp_addr)) ?
                fw_sp_data_ff : sp_rd_ff;
      acc     = c_op_ff.valid && (c_op_ff.kind == KIND_ACC);
   end

   // Write port: clearing sweep has the RAMs to itself
   always_comb begin
      tot_we    = clr_busy_ff || acc;
      sp_we     = clr_busy_ff || acc;
      tot_waddr = clr_busy_ff ? clr_idx_ff[TOT_AW-1:0] : c_tot_addr;
      sp_waddr  = clr_busy_ff ? clr_idx_ff : c_sp_addr;
      tot_wdata = clr_busy_ff ? '0 : sat_inc(tot_cur);
      sp_wdata  = clr_busy_ff ? '0 : sat_inc(sp_cur);
   end

   always_ff @(posedge clock) begin
      if (tot_we) begin
         total_ram_ff[tot_waddr] <= tot_wdata;
      end
      tot_rd_ff <= total_ram_ff[tot_raddr];
   end

   always_ff @(posedge clock) begin
      if (sp_we) begin
         species_ram_ff[sp_waddr] <= sp_wdata;
      end
      sp_rd_ff <= species_ram_ff[sp_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_tot_valid_ff <= 1'b0;
         fw_sp_valid_ff  <= 1'b0;
      end else begin
         fw_tot_valid_ff <= acc;
         fw_sp_valid_ff  <= acc;
      end
   end

   always_ff @(posedge clock) begin
      fw_tot_addr_ff <= c_tot_addr;
      fw_sp_addr_ff  <= c_sp_addr;
      fw_tot_data_ff <= tot_wdata;
      fw_sp_data_ff  <= sp_wdata;
   end

   // Sweep every species entry once; totals are covered along the way
   always_comb begin
      clr_idx_in  = clr_idx_ff + 1'b1;
      clr_busy_in = clr_busy_ff && (clr_idx_ff != '1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // Read result
   always_comb begin
      push = c_op_ff.valid && (c_op_ff.kind == KIND_READ);
      unique case (c_op_ff.src)
         SRC_TOTAL:   push_data = tot_cur;
         SRC_SPECIES: push_data = sp_cur;
         default:     push_data = '0;
      endcase
   end

   // No memory op may reach the write stage while the sweep runs
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !c_op_ff.valid)
      else $error("memory op during clearing sweep");

   // An accumulate always leaves both counters nonzero
   a_acc_nonzero: assert property (@(posedge clock) disable iff (reset)
      acc |-> (tot_wdata != '0) && (sp_wdata != '0))
      else $error("accumulate wrote a zero count");

   // Total and species writes of one particle hit the same layer and bin
   a_addr_pair: assert property (@(posedge clock) disable iff (reset)
      acc |-> (sp_waddr[SP_AW-1] == tot_waddr[TOT_AW-1]) &&
              (sp_waddr[BIN_W-1:0] == tot_waddr[BIN_W-1:0]))
      else $error("total and species write addresses disagree");

   // Forwarding holds nothing stale when the sweep ends
   a_fwd_clean: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> !fw_tot_valid_ff && !fw_sp_valid_ff)
      else $error("forwarding entry valid at end of sweep");

endmodule

[hdl/ldh_rsp_queue.sv]
// Layer density histogram: response queue. Small register FIFO holding
// read results until the receiver takes them. Depends on ldh_pkg.
module ldh_rsp_queue
   import ldh_pkg::*;
#(
   parameter int DEPTH   = RSP_DEPTH,
   localparam int PTR_W  = $clog2(DEPTH),
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [COUNT_W-1:0] push_data,
   input  logic               pop,
   output logic               out_valid,
   output logic [COUNT_W-1:0] out_data
);

   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [COUNT_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];

endmodule

[hdl/layer_density_histogram.sv]
// Layer density histogram: top level. Configuration registers, request
// credit, and the front end, counter store and response queue.
// Depends on ldh_pkg, ldh_front, ldh_store, ldh_rsp_queue.
//
// Usage:
//   req_ beats carry one particle (opcode accumulate) or one counter read
//   (opcode read). An accumulate bins x, picks the bottom or top layer from
//   z and bumps the layer total and the species counter; it returns nothing.
//   A read returns one saturating 32-bit count on the rsp_ channel, in order.
//   csr_ writes set bin scale, layer thickness and the two wall positions;
//   csr_ready is always high.
// Timing:
//   A read passes stages A, P and C, then the response queue. Accumulates
//   and reads are taken one per cycle while req_ready is high; the counter
//   RAMs do one read-modify-write per cycle, with forwarding between neighbor
//   beats. Up to four reads may be outstanding; when the receiver stalls, the
//   response queue fills and req_ready drops until results drain.
// Reset:
//   All counters clear by a sweep of 4 * 2**ceil(log2(NUM_BINS)) entries
//   (16384 at the default), one entry per cycle; req_ready stays low until
//   it ends. Configuration writes are taken during the sweep.
module layer_density_histogram
   import ldh_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   input  logic [COORD_W-1:0]   req_x_position,
   input  logic [COORD_W-1:0]   req_z_position,
   input  logic [SPEC_W-1:0]    req_species,
   input  logic [HSEL_W-1:0]    req_read_histogram,
   input  logic [RBIN_W-1:0]    req_read_bin,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COUNT_W-1:0]   rsp_count,
   // configuration channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int BIN_W = $clog2(NUM_BINS);
   localparam int PEND_W = $clog2(RSP_DEPTH + 1);
   localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(RSP_DEPTH);

   logic [SCALE_W-1:0] bin_scale_ff;
   logic [COORD_W-1:0] thickness_ff, bottom_ff, top_ff;
   logic [PEND_W-1:0]  pend_ff, pend_in;

   logic               req_accept, read_accept, rsp_accept, csr_accept;
   logic               clear_busy, push;
   logic [COUNT_W-1:0] push_data;
   mem_op_type         op;
   logic [BIN_W-1:0]   op_bin;

   assign csr_ready   = 1'b1;
   assign csr_accept  = csr_valid && csr_ready;
   assign req_ready   = !clear_busy && (pend_ff != PEND_MAX);
   assign req_accept  = req_valid && req_ready;
   assign read_accept = req_accept && (req_opcode == OPC_READ);
   assign rsp_accept  = rsp_valid && rsp_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_scale_ff <= BIN_SCALE_RST;
         thickness_ff <= THICKNESS_RST;
         bottom_ff    <= BOTTOM_RST;
         top_ff       <= TOP_RST;
      end else if (csr_accept) begin
         unique case (csr_index)
            CSR_BIN_SCALE:       bin_scale_ff <= csr_wdata;
            CSR_LAYER_THICKNESS: thickness_ff <= csr_wdata[COORD_W-1:0];
            CSR_BOTTOM_SURFACE:  bottom_ff    <= csr_wdata[COORD_W-1:0];
            CSR_TOP_SURFACE:     top_ff       <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // Outstanding reads, bounded by the queue depth
   always_comb begin
      pend_in = pend_ff;
      if (read_accept && !rsp_accept) begin
         pend_in = pend_ff + 1'b1;
      end else if (rsp_accept && !read_accept) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   ldh_front #(.NUM_BINS(NUM_BINS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_accept       (req_accept),
      .in_opcode       (req_opcode),
      .in_x            (req_x_position),
      .in_z            (req_z_position),
      .in_species      (req_species),
      .in_rhist        (req_read_histogram),
      .in_rbin         (req_read_bin),
      .bin_scale       (bin_scale_ff),
      .layer_thickness (thickness_ff),
      .bottom_surface  (bottom_ff),
      .top_surface     (top_ff),
      .op              (op),
      .op_bin          (op_bin)
   );

   ldh_store #(.NUM_BINS(NUM_BINS)) u_store (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .op_bin     (op_bin),
      .clear_busy (clear_busy),
      .push       (push),
      .push_data  (push_data)
   );

   ldh_rsp_queue #(.DEPTH(RSP_DEPTH)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_accept),
      .out_valid (rsp_valid),
      .out_data  (rsp_count)
   );

endmodule

[tb/tb_layer_density_histogram.sv]
// Testbench for layer_density_histogram: particle beats, counter reads and register
// writes, with every read result checked against a local counter image.
// Depends on ldh_pkg and the layer_density_histogram top level.
module tb_layer_density_histogram;
   import ldh_pkg::*;

   localparam int NUM_BINS     = NUM_BINS_DEF;
   localparam int HIST_SLOTS   = 6;
   localparam int COORD_MAX    = (1 << COORD_W) - 1;
   localparam int RSP_LATENCY  = 3;
   localparam int DRAIN_CYCLES = 4 * RSP_LATENCY;
   // covers the post-reset clearing sweep with plenty of room
   localparam int STALL_LIMIT  = 60000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 55;
   localparam int RECENT_BINS  = 16;
   localparam int REPORT_MAX   = 10;

   localparam logic [SPEC_W-1:0] SPECIES_OTHER = 2'd2;
   localparam logic [SPEC_W-1:0] SPECIES_SPARE = 2'd3;

   typedef enum int {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PATTERN
   } rx_mode_type;

   typedef struct {
      logic               opcode;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] z;
      logic [SPEC_W-1:0]  species;
      logic [HSEL_W-1:0]  rhist;
      logic [RBIN_W-1:0]  rbin;
   } density_req_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_opcode;
   logic [COORD_W-1:0]   req_x_position;
   logic [COORD_W-1:0]   req_z_position;
   logic [SPEC_W-1:0]    req_species;
   logic [HSEL_W-1:0]    req_read_histogram;
   logic [RBIN_W-1:0]    req_read_bin;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [COUNT_W-1:0]   rsp_count;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   // Local copy of the block's registers and counters
   logic [SCALE_W-1:0] cfg_bin_scale = BIN_SCALE_RST;
   logic [COORD_W-1:0] cfg_thickness = THICKNESS_RST;
   logic [COORD_W-1:0] cfg_bottom    = BOTTOM_RST;
   logic [COORD_W-1:0] cfg_top       = TOP_RST;
   logic [COUNT_W-1:0] counter_image [HIST_SLOTS*NUM_BINS];

   logic [COUNT_W-1:0] expected_counts [$];
   int                 touched_bins [$];
   int                 mismatch_count = 0;

   // Sender and receiver pacing
   bit gaps_on       = 1'b1;
   int burst_left    = 0;
   int hold_requests = 0;
   bit hold_active   = 1'b0;

   layer_density_histogram #(.NUM_BINS(NUM_BINS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_x_position     (req_x_position),
      .req_z_position     (req_z_position),
      .req_species        (req_species),
      .req_read_histogram (req_read_histogram),
      .req_read_bin       (req_read_bin),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_count          (rsp_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Saturating bump of one counter in the image
   task automatic bump_counter(input int sel, input int bin);
      int slot;
      slot = sel * NUM_BINS + bin;
      if (counter_image[slot] != '1) begin
         counter_image[slot] = counter_image[slot] + 1'b1;
      end
   endtask

   // Append one expected read result
   task automatic expect_count(input logic [COUNT_W-1:0] value);
      expected_counts = {expected_counts, value};
   endtask

   // Remember a recently counted bin so reads can aim at it
   task automatic note_bin(input int bin);
      touched_bins = {touched_bins, bin};
      if (touched_bins.size() > RECENT_BINS) void'(touched_bins.pop_front());
   endtask

   // Apply one accepted beat to the image; a read queues its expected count
   task automatic histogram_predict(input density_req_type b);
      logic [PROD_W-1:0]    product;
      int                   bin;
      longint unsigned      z;
      hist_sel_type         total_sel;
      hist_sel_type         first_sel;
      hist_sel_type         second_sel;
      bit                   in_layer;
      if (b.opcode == OPC_READ) begin
         if (b.rhist <= HIST_TOP_FIRST && b.rbin < NUM_BINS) begin
            expect_count(counter_image[int'(b.rhist) * NUM_BINS + int'(b.rbin)]);
         end else begin
            expect_count('0);
         end
      end else begin
         product  = PROD_W'(b.x) * PROD_W'(cfg_bin_scale);
         bin      = int'(product >> BIN_SHIFT);
         z        = 64'(b.z);
         in_layer = 1'b0;
         if (bin < NUM_BINS) begin
            note_bin(bin);
            // bottom layer wins where the two overlap
            if (z >= cfg_bottom && z < z - z + cfg_bottom + cfg_thickness) begin
               in_layer   = 1'b1;
               total_sel  = HIST_BOT_TOTAL;
               first_sel  = HIST_BOT_FIRST;
               second_sel = HIST_BOT_SECOND;
            end else if (z < cfg_top && z + cfg_thickness >= cfg_top) begin
               in_layer   = 1'b1;
               total_sel  = HIST_TOP_TOTAL;
               first_sel  = HIST_TOP_FIRST;
               second_sel = HIST_TOP_SECOND;
            end
         end
         if (in_layer && b.species == SPECIES_FIRST) begin
            bump_counter(int'(first_sel), bin);
            bump_counter(int'(total_sel), bin);
         end else if (in_layer && b.species == SPECIES_SECOND) begin
            bump_counter(int'(second_sel), bin);
            bump_counter(int'(total_sel), bin);
         end
      end
   endtask

   // Offer one beat, hold it until taken, then maybe open a gap
   task automatic send_item(input density_req_type b);
      int gap;
      req_valid          <= 1'b1;
      req_opcode         <= b.opcode;
      req_x_position     <= b.x;
      req_z_position     <= b.z;
      req_species        <= b.species;
      req_read_histogram <= b.rhist;
      req_read_bin       <= b.rbin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      histogram_predict(b);
      if (gaps_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 15);
            gap        = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Unused fields of a beat carry random bits
   function automatic density_req_type accum_beat(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] z,
                                                  input logic [SPEC_W-1:0]  species);
      density_req_type b;
      b.opcode  = OPC_ACCUM;
      b.x       = x;
      b.z       = z;
      b.species = species;
      b.rhist   = HSEL_W'($urandom);
      b.rbin    = RBIN_W'($urandom);
      return b;
   endfunction

   function automatic density_req_type read_beat(input logic [HSEL_W-1:0] hist,
                                                 input logic [RBIN_W-1:0] bin);
      density_req_type b;
      b.opcode  = OPC_READ;
      b.x       = COORD_W'($urandom);
      b.z       = COORD_W'($urandom);
      b.species = SPEC_W'($urandom);
      b.rhist   = hist;
      b.rbin    = bin;
      return b;
   endfunction

   // Mostly binnable particles aimed at the layers, reads aimed at recent bins
   function automatic density_req_type random_beat();
      density_req_type b;
      longint       x_top;
      longint       z;
      longint       bot;
      longint       thk;
      longint       top;
      longint       lo;
      int           pick;
      b.opcode  = ($urandom_range(0, 99) < 35) ? OPC_READ : OPC_ACCUM;
      b.x       = COORD_W'($urandom);
      b.z       = COORD_W'($urandom);
      b.species = SPEC_W'($urandom);
      b.rhist   = HSEL_W'($urandom);
      b.rbin    = RBIN_W'($urandom);
      if (b.opcode == OPC_READ) begin
         if ($urandom_range(0, 9) != 0) begin
            b.rhist = HSEL_W'($urandom_range(0, int'(HIST_TOP_FIRST)));
         end
         if (touched_bins.size() != 0 && $urandom_range(0, 9) < 7) begin
            b.rbin = RBIN_W'(touched_bins[$urandom_range(0, touched_bins.size() - 1)]);
         end
      end else begin
         x_top = ((longint'(NUM_BINS) << BIN_SHIFT) - 1) / longint'(cfg_bin_scale);
         if (x_top > COORD_MAX) x_top = COORD_MAX;
         if ($urandom_range(0, 99) < 85) b.x = COORD_W'($urandom_range(0, 32'(x_top)));
         bot  = cfg_bottom;
         thk  = cfg_thickness;
         top  = cfg_top;
         z    = -1;
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            if (thk != 0) z = bot + longint'($urandom_range(0, 32'(thk - 1)));
         end else if (pick < 75) begin
            lo = top - thk;
            if (lo < 0) lo = 0;
            if (top > lo) z = lo + longint'($urandom_range(0, 32'(top - lo - 1)));
         end else if (pick < 90) begin
            // one step either side of the layer edges
            case ($urandom_range(0, 3))
               0:       z = bot - 1;
               1:       z = bot + thk;
               2:       z = top;
               default: z = top - thk - 1;
            endcase
         end
         if (z >= 0 && z <= COORD_MAX) b.z = COORD_W'(z);
         pick = $urandom_range(0, 99);
         if (pick < 45)      b.species = SPECIES_FIRST;
         else if (pick < 85) b.species = SPECIES_SECOND;
         else if (pick < 93) b.species = SPECIES_OTHER;
         else                b.species = SPECIES_SPARE;
      end
      return b;
   endfunction

   // Stop offering, let every read result arrive and the pipeline settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BIN_SCALE:       cfg_bin_scale = value[SCALE_W-1:0];
         CSR_LAYER_THICKNESS: cfg_thickness = value[COORD_W-1:0];
         CSR_BOTTOM_SURFACE:  cfg_bottom    = value[COORD_W-1:0];
         CSR_TOP_SURFACE:     cfg_top       = value[COORD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [SCALE_W-1:0] scale,
                             input logic [COORD_W-1:0] thick,
                             input logic [COORD_W-1:0] bottom,
                             input logic [COORD_W-1:0] top);
      wait_drained();
      write_reg(CSR_BIN_SCALE, CSR_DAT_W'(scale));
      write_reg(CSR_LAYER_THICKNESS, CSR_DAT_W'(thick));
      write_reg(CSR_BOTTOM_SURFACE, CSR_DAT_W'(bottom));
      write_reg(CSR_TOP_SURFACE, CSR_DAT_W'(top));
      csr_valid <= 1'b0;
   endtask

   // Reset settings: layer edges, last bin, dropped bins, every histogram select
   task automatic test_reset_defaults();
      send_item(accum_beat(0, 0, SPECIES_FIRST));
      send_item(accum_beat(0, 1484, SPECIES_SECOND));       // top of bottom layer
      send_item(accum_beat(0, 1485, SPECIES_FIRST));        // just above it
      send_item(accum_beat(0, 700, SPECIES_OTHER));         // other species, in layer
      send_item(accum_beat(COORD_W'(COORD_MAX), 0, SPECIES_FIRST)); // far past the last bin
      send_item(accum_beat(83886, 1048574, SPECIES_FIRST)); // last bin, top layer
      send_item(accum_beat(83887, 1048574, SPECIES_SECOND));// first bin past the end
      send_item(accum_beat(83886, COORD_W'(COORD_MAX), SPECIES_SECOND)); // z at the top wall
      for (int h = 0; h < (1 << HSEL_W); h++) begin
         send_item(read_beat(HSEL_W'(h), 0));
      end
      send_item(read_beat(HIST_TOP_TOTAL, RBIN_W'(NUM_BINS - 1)));
      send_item(read_beat(HIST_TOP_FIRST, RBIN_W'(NUM_BINS - 1)));
   endtask

   // Zero thickness, then overlapping layers with the top edge below zero
   task automatic test_layer_overlap();
      set_config(BIN_SCALE_RST, 0, 0, COORD_W'(COORD_MAX));
      send_item(accum_beat(21, 0, SPECIES_FIRST));
      send_item(read_beat(HIST_BOT_TOTAL, 1));
      set_config(BIN_SCALE_RST, 500, 100, 200);
      send_item(accum_beat(21, 150, SPECIES_SECOND)); // both layers, bottom wins
      send_item(accum_beat(21, 50, SPECIES_FIRST));   // top layer clamped at zero
      send_item(accum_beat(21, 99, SPECIES_SECOND));
      send_item(accum_beat(21, 200, SPECIES_FIRST));  // at the top wall: bottom layer
      send_item(read_beat(HIST_BOT_TOTAL, 1));
      send_item(read_beat(HIST_TOP_TOTAL, 1));
      send_item(read_beat(HIST_TOP_FIRST, 1));
   endtask

   // Receiver holds off while reads keep coming, so the input stalls
   task automatic test_input_stall();
      gaps_on = 1'b0;
      for (int i = 0; i < 4; i++) begin
         send_item(accum_beat(21, 150, SPECIES_FIRST));
      end
      // nothing on offer while the hold-off starts
      req_valid <= 1'b0;
      hold_requests++;
      while (!hold_active) @(posedge clock);
      for (int i = 0; i < 32; i++) begin
         send_item(read_beat(HSEL_W'($urandom_range(0, int'(HIST_TOP_FIRST))),
                             RBIN_W'($urandom_range(0, 3))));
      end
      gaps_on = 1'b1;
   endtask

   // Random phases, each under its own register setting
   task automatic test_random_phases();
      logic [SCALE_W-1:0] s;
      logic [COORD_W-1:0] t;
      logic [COORD_W-1:0] lo;
      logic [COORD_W-1:0] hi;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               s = '1;
               t = '1;
               lo = '0;
               hi = '1;
            end
            1: begin
               s = 1;
               t = COORD_W'($urandom_range(0, 64));
               lo = '1;
               hi = '0;
            end
            2: begin
               s = BIN_SCALE_RST;
               t = THICKNESS_RST;
               lo = BOTTOM_RST;
               hi = TOP_RST;
            end
            default: begin
               s  = SCALE_W'($urandom_range(1 << 14, 1 << 22));
               t  = COORD_W'($urandom_range(0, 1 << 16));
               lo = COORD_W'($urandom_range(0, 1 << 18));
               hi = COORD_W'($urandom_range(1 << 19, COORD_MAX));
               if ($urandom_range(0, 3) == 0) begin
                  s  = SCALE_W'($urandom_range(1, (1 << SCALE_W) - 1));
                  t  = COORD_W'($urandom);
                  lo = COORD_W'($urandom);
                  hi = COORD_W'($urandom);
               end
            end
         endcase
         set_config(s, t, lo, hi);
         gaps_on = (p != 3 && p != 6);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_item(random_beat());
         end
      end
      gaps_on = 1'b1;
   endtask

   // Receiver: own stall pattern, plus long hold-offs on request
   initial begin : receiver
      rx_mode_type mode;
      int       mode_left;
      int       holds_seen;
      int       hold_left;
      bit [7:0] pattern;
      rsp_ready  = 1'b0;
      mode       = RX_ALWAYS;
      mode_left  = 0;
      holds_seen = 0;
      hold_left  = 0;
      pattern    = 8'hff;
      forever begin
         @(posedge clock);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            hold_active = 1'b1;
            rsp_ready  <= 1'b0;
         end else begin
            hold_active = 1'b0;
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 200);
               pattern   = 8'($urandom) | 8'h01;
            end else begin
               mode_left--;
            end
            case (mode)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
               default: begin
                  rsp_ready <= pattern[0];
                  pattern = {pattern[0], pattern[7:1]};
               end
            endcase
         end
      end
   end

   // Each result beat against the oldest expected count
   always @(posedge clock) begin : result_check
      logic [COUNT_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_counts.size() == 0) begin
            if (mismatch_count < REPORT_MAX) begin
               $display("result beat with nothing expected: count=%0d", rsp_count);
            end
            mismatch_count++;
         end else begin
            want = expected_counts.pop_front();
            if (rsp_count !== want) begin
               if (mismatch_count < REPORT_MAX) begin
                  $display("count mismatch: expected %0d, got %0d", want, rsp_count);
               end
               mismatch_count++;
            end
         end
      end
   end

   // Ends the run if no channel moves a beat for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("tb_layer_density_histogram: done, errors");
      $finish;
   end

   initial begin : stimulus
      foreach (counter_image[i]) counter_image[i] = '0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_opcode         = OPC_ACCUM;
      req_x_position     = '0;
      req_z_position     = '0;
      req_species        = '0;
      req_read_histogram = '0;
      req_read_bin       = '0;
      csr_valid          = 1'b0;
      csr_index          = CSR_BIN_SCALE;
      csr_wdata          = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_layer_overlap();
      test_input_stall();
      test_random_phases();
      wait_drained();

      if (mismatch_count == 0 && expected_counts.size() == 0) begin
         $display("tb_layer_density_histogram: done, clean");
      end else begin
         $display("tb_layer_density_histogram: done, errors");
      end
      $finish;
   end

endmodule
